@@ rtl/acd_pkg.sv @@
// ----------------------------------------------------------------------------
// acd_pkg
// Shared widths, fixed-point constants and helpers for the acrobot
// dynamics derivative pipeline.
// ----------------------------------------------------------------------------
package acd_pkg;

    // Fixed-point format of all operands and results
    localparam int FRAC_BITS    = 12;
    localparam int ANG_BITS     = 28;
    localparam int CORDIC_STEPS = 28;

    // Field widths
    localparam int SH_ANG_W = 15;
    localparam int EL_ANG_W = 15;
    localparam int RATE_W   = 16;
    localparam int TRIG_W   = 16;
    localparam int ACC_W    = 20;

    // Internal widths
    localparam int ANG_W = 34;   // angle in Q28 before reduction
    localparam int XY_W  = 32;   // CORDIC x / y
    localparam int D_W   = 18;   // mass matrix terms
    localparam int P_W   = 24;   // first product stage
    localparam int Q_W   = 26;   // second product stage
    localparam int R_W   = 28;   // right-hand side
    localparam int NUM_W = 48;   // numerators
    localparam int DET_W = 24;   // determinant, positive
    localparam int REM_W = DET_W + ACC_W;

    // Angle constants in Q28
    localparam logic signed [ANG_W-1:0] PI_Q      = 34'sd843314857;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q  = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q = 34'sd421657428;
    localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 32'sd163008218;

    // Round a Q30 constant to Q.FRAC_BITS
    function automatic longint qconst(input longint q30);
        return (q30 + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    endfunction

    // Model constants: 2.7, 1.25, 14.715 and 4.905
    localparam logic signed [D_W-1:0] K27  = D_W'(qconst(64'sd2899102925));
    localparam logic signed [D_W-1:0] K125 = D_W'(qconst(64'sd1342177280));
    localparam logic signed [D_W-1:0] KG1  = D_W'(qconst(64'sd15800110940));
    localparam logic signed [D_W-1:0] KG2  = D_W'(qconst(64'sd5266703647));

    // Round a double-precision product back to Q.FRAC_BITS, half up
    function automatic logic signed [NUM_W-1:0] qrnd(input logic signed [NUM_W-1:0] p);
        return (p + $signed(NUM_W'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    // Arctangent of 2^-i in Q28
    function automatic logic signed [ANG_W-1:0] atan_q28(input int i);
        logic signed [ANG_W-1:0] v;
        case (i)
            0:       v = 34'sd210828714;
            1:       v = 34'sd124459457;
            2:       v = 34'sd65760959;
            3:       v = 34'sd33381290;
            4:       v = 34'sd16755422;
            5:       v = 34'sd8385879;
            6:       v = 34'sd4193963;
            7:       v = 34'sd2097109;
            8:       v = 34'sd1048571;
            9:       v = 34'sd524287;
            default: v = ANG_W'(1) <<< (ANG_BITS - i);
        endcase
        return v;
    endfunction

endpackage

@@ rtl/acd_item_if.sv @@
// ----------------------------------------------------------------------------
// acd_item_if
// Input channel: one acrobot state plus elbow torque per beat.
// ----------------------------------------------------------------------------
interface acd_item_if import acd_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic        [SH_ANG_W-1:0] shoulder_angle;
    logic signed [EL_ANG_W-1:0] elbow_angle;
    logic signed [RATE_W-1:0]   shoulder_rate;
    logic signed [RATE_W-1:0]   elbow_rate;
    logic signed [RATE_W-1:0]   elbow_torque;

    modport source (
        output valid, shoulder_angle, elbow_angle, shoulder_rate, elbow_rate,
               elbow_torque,
        input  ready
    );

    modport sink (
        input  valid, shoulder_angle, elbow_angle, shoulder_rate, elbow_rate,
               elbow_torque,
        output ready
    );

endinterface

@@ rtl/acd_result_if.sv @@
// ----------------------------------------------------------------------------
// acd_result_if
// Output channel: both joint accelerations per beat.
// ----------------------------------------------------------------------------
interface acd_result_if import acd_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [ACC_W-1:0] shoulder_accel;
    logic signed [ACC_W-1:0] elbow_accel;

    modport source (
        output valid, shoulder_accel, elbow_accel,
        input  ready
    );

    modport sink (
        input  valid, shoulder_accel, elbow_accel,
        output ready
    );

endinterface

@@ rtl/acd_cordic.sv @@
// ----------------------------------------------------------------------------
// acd_cordic
// Pipelined sine / cosine: range reduction in three stages, one CORDIC
// rotation per stage, then sign flip and rounding.
// ----------------------------------------------------------------------------
module acd_cordic import acd_pkg::*; (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [ANG_W-1:0]  ang,
    output logic signed [TRIG_W-1:0] cos_q,
    output logic signed [TRIG_W-1:0] sin_q
);

    localparam int OUT_SHIFT = ANG_BITS - FRAC_BITS;
    localparam logic signed [XY_W-1:0] OUT_RND = XY_W'(1) <<< (OUT_SHIFT - 1);

    logic signed [ANG_W-1:0] mod_reg,  mod_next;
    logic signed [ANG_W-1:0] wrap_reg, wrap_next;
    logic signed [ANG_W-1:0] fold_next;
    logic                    flip_next;

    logic signed [ANG_W-1:0] z_reg    [CORDIC_STEPS+1];
    logic signed [XY_W-1:0]  x_reg    [CORDIC_STEPS+1];
    logic signed [XY_W-1:0]  y_reg    [CORDIC_STEPS+1];
    logic                    flip_reg [CORDIC_STEPS+1];

    logic signed [XY_W-1:0]   xf, yf;
    logic signed [TRIG_W-1:0] cos_reg, cos_next, sin_reg, sin_next;

    // Reduction: remainder by 2pi (toward zero), wrap to [-pi,pi], fold
    always_comb
    begin
        if (ang >= TWO_PI_Q)
            mod_next = ang - TWO_PI_Q;
        else if (ang <= -TWO_PI_Q)
            mod_next = ang + TWO_PI_Q;
        else
            mod_next = ang;

        if (mod_reg > PI_Q)
            wrap_next = mod_reg - TWO_PI_Q;
        else if (mod_reg < -PI_Q)
            wrap_next = mod_reg + TWO_PI_Q;
        else
            wrap_next = mod_reg;

        flip_next = 1'b1;
        if (wrap_reg > HALF_PI_Q)
            fold_next = wrap_reg - PI_Q;
        else if (wrap_reg < -HALF_PI_Q)
            fold_next = wrap_reg + PI_Q;
        else
        begin
            fold_next = wrap_reg;
            flip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mod_reg     <= mod_next;
            wrap_reg    <= wrap_next;
            z_reg[0]    <= fold_next;
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            flip_reg[0] <= flip_next;
        end
    end

    // One rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        logic signed [XY_W-1:0]  dx, dy, x_next, y_next;
        logic signed [ANG_W-1:0] z_next;

        always_comb
        begin
            dx = x_reg[i] >>> i;
            dy = y_reg[i] >>> i;
            if (!z_reg[i][ANG_W-1])
            begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + dx;
                z_next = z_reg[i] - atan_q28(i);
            end
            else
            begin
                x_next = x_reg[i] + dy;
                y_next = y_reg[i] - dx;
                z_next = z_reg[i] + atan_q28(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                flip_reg[i+1] <= flip_reg[i];
            end
        end
    end

    // Undo the fold and round to Q.FRAC_BITS
    always_comb
    begin
        xf       = flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
        yf       = flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        cos_next = TRIG_W'((xf + OUT_RND) >>> OUT_SHIFT);
        sin_next = TRIG_W'((yf + OUT_RND) >>> OUT_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

@@ rtl/acrobot_dynamics_derivative_unit.sv @@
// ----------------------------------------------------------------------------
// acrobot_dynamics_derivative_unit
// Joint accelerations of the acrobot from state and elbow torque.
// ----------------------------------------------------------------------------
// Pipeline: the CORDIC units, then 4 arithmetic stages, 1 divider setup
//   stage, 20 divider bit stages and 1 output stage from input to result.
// Throughput: one beat per cycle; a stalled output freezes the whole pipe.
// Reset: rst_n clears the valid bits only; data registers are not reset.
// ----------------------------------------------------------------------------
module acrobot_dynamics_derivative_unit import acd_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    acd_item_if.sink    item,
    acd_result_if.source result
);

    localparam int CORDIC_LAT = CORDIC_STEPS + 4;
    localparam int DIV_STEPS  = ACC_W;
    localparam int V_A1       = CORDIC_LAT;
    localparam int V_D0       = CORDIC_LAT + 4;
    localparam int V_OUT      = V_D0 + DIV_STEPS + 1;
    localparam int NSTAGE     = V_OUT + 1;
    localparam int UP_SHIFT   = ANG_BITS - FRAC_BITS;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    logic                adv;
    logic [NSTAGE-1:0]   vld_reg;

    // Pipeline advances unless the output beat is stalled
    assign adv          = !vld_reg[V_OUT] || result.ready;
    assign item.ready   = adv;
    assign result.valid = vld_reg[V_OUT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTAGE-2:0], item.valid};
    end

    // ---------------- angles and trig ----------------
    logic signed [ANG_W-1:0]  ang_el, ang_sh, ang_sum;
    logic signed [TRIG_W-1:0] c2, s2, ca, sa, cb, sb;

    always_comb
    begin
        ang_el  = ANG_W'(item.elbow_angle) <<< UP_SHIFT;
        ang_sh  = (ANG_W'($signed({1'b0, item.shoulder_angle})) <<< UP_SHIFT) - HALF_PI_Q;
        ang_sum = ((ANG_W'($signed({1'b0, item.shoulder_angle}))
                    + ANG_W'(item.elbow_angle)) <<< UP_SHIFT) - HALF_PI_Q;
    end

    acd_cordic u_cordic_el  (.clk(clk), .en(adv), .ang(ang_el),  .cos_q(c2), .sin_q(s2));
    acd_cordic u_cordic_sh  (.clk(clk), .en(adv), .ang(ang_sh),  .cos_q(ca), .sin_q(sa));
    acd_cordic u_cordic_sum (.clk(clk), .en(adv), .ang(ang_sum), .cos_q(cb), .sin_q(sb));

    // Rates and torque ride alongside the CORDIC units
    logic signed [RATE_W-1:0] w1_dly_reg  [CORDIC_LAT];
    logic signed [RATE_W-1:0] w2_dly_reg  [CORDIC_LAT];
    logic signed [RATE_W-1:0] tau_dly_reg [CORDIC_LAT];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w1_dly_reg[0]  <= item.shoulder_rate;
            w2_dly_reg[0]  <= item.elbow_rate;
            tau_dly_reg[0] <= item.elbow_torque;
            for (int i = 1; i < CORDIC_LAT; i++)
            begin
                w1_dly_reg[i]  <= w1_dly_reg[i-1];
                w2_dly_reg[i]  <= w2_dly_reg[i-1];
                tau_dly_reg[i] <= tau_dly_reg[i-1];
            end
        end
    end

    // ---------------- stage A1: first products ----------------
    logic signed [RATE_W-1:0] w1, w2;
    logic signed [17:0]       sum_w;
    logic signed [33:0]       p1_prod, g2_prod, ga_prod;
    logic signed [31:0]       p2_prod;
    logic signed [D_W-1:0]    d11_a1_reg, d11_a1_next, d12_a1_reg, d12_a1_next;
    logic signed [P_W-1:0]    p1_reg, p1_next, p2_reg, p2_next;
    logic signed [P_W-1:0]    gr2_a1_reg, gr2_a1_next, ga_reg, ga_next;
    logic signed [TRIG_W-1:0] s2_reg;
    logic signed [RATE_W-1:0] tau_a1_reg;

    always_comb
    begin
        w1          = w1_dly_reg[CORDIC_LAT-1];
        w2          = w2_dly_reg[CORDIC_LAT-1];
        sum_w       = 18'(w2) + (18'(w1) <<< 1);
        p1_prod     = w2 * sum_w;
        p2_prod     = w1 * w1;
        g2_prod     = KG2 * cb;
        ga_prod     = KG1 * ca;
        d11_a1_next = K27 + D_W'(c2);
        d12_a1_next = K125 + ((D_W'(c2) + $signed(D_W'(1))) >>> 1);
        p1_next     = P_W'(qrnd(NUM_W'(p1_prod)));
        p2_next     = P_W'(qrnd(NUM_W'(p2_prod)));
        gr2_a1_next = P_W'(qrnd(NUM_W'(g2_prod)));
        ga_next     = P_W'(qrnd(NUM_W'(ga_prod)));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d11_a1_reg <= d11_a1_next;
            d12_a1_reg <= d12_a1_next;
            p1_reg     <= p1_next;
            p2_reg     <= p2_next;
            gr2_a1_reg <= gr2_a1_next;
            ga_reg     <= ga_next;
            s2_reg     <= s2;
            tau_a1_reg <= tau_dly_reg[CORDIC_LAT-1];
        end
    end

    // ---------------- stage A2: Coriolis, gravity sum, matrix products ----------------
    logic signed [39:0]       q1_prod, q2_prod;
    logic signed [35:0]       dd_prod, sq_prod;
    logic signed [Q_W-1:0]    q1_reg, q1_next, q2_reg, q2_next, gr1_reg, gr1_next;
    logic signed [P_W-1:0]    dd_reg, dd_next, sq_reg, sq_next, gr2_a2_reg;
    logic signed [D_W-1:0]    d11_a2_reg, d12_a2_reg;
    logic signed [RATE_W-1:0] tau_a2_reg;

    always_comb
    begin
        q1_prod  = s2_reg * p1_reg;
        q2_prod  = s2_reg * p2_reg;
        dd_prod  = d11_a1_reg * K125;
        sq_prod  = d12_a1_reg * d12_a1_reg;
        q1_next  = Q_W'(qrnd(NUM_W'(q1_prod)));
        q2_next  = Q_W'(qrnd(NUM_W'(q2_prod)));
        gr1_next = Q_W'(ga_reg) + Q_W'(gr2_a1_reg);
        dd_next  = P_W'(qrnd(NUM_W'(dd_prod)));
        sq_next  = P_W'(qrnd(NUM_W'(sq_prod)));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q1_reg     <= q1_next;
            q2_reg     <= q2_next;
            gr1_reg    <= gr1_next;
            dd_reg     <= dd_next;
            sq_reg     <= sq_next;
            gr2_a2_reg <= gr2_a1_reg;
            d11_a2_reg <= d11_a1_reg;
            d12_a2_reg <= d12_a1_reg;
            tau_a2_reg <= tau_a1_reg;
        end
    end

    // ---------------- stage A3: right-hand side and determinant ----------------
    logic signed [R_W-1:0]   r1_reg, r1_next, r2_reg, r2_next;
    logic signed [P_W-1:0]   det_diff;
    logic        [DET_W-1:0] det_a3_reg, det_a3_next;
    logic signed [D_W-1:0]   d11_a3_reg, d12_a3_reg;

    always_comb
    begin
        // half of each Coriolis term, rounded half up
        r1_next  = ((R_W'(q1_reg) + $signed(R_W'(1))) >>> 1) - R_W'(gr1_reg);
        r2_next  = R_W'(tau_a2_reg) - ((R_W'(q2_reg) + $signed(R_W'(1))) >>> 1)
                   - R_W'(gr2_a2_reg);
        det_diff = dd_reg - sq_reg;
        if (det_diff < $signed(P_W'(1)))
            det_a3_next = DET_W'(1);
        else
            det_a3_next = DET_W'(det_diff);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg     <= r1_next;
            r2_reg     <= r2_next;
            det_a3_reg <= det_a3_next;
            d11_a3_reg <= d11_a2_reg;
            d12_a3_reg <= d12_a2_reg;
        end
    end

    // ---------------- stage A4: numerators ----------------
    logic signed [NUM_W-1:0] n_reg [2];
    logic signed [NUM_W-1:0] n_next [2];
    logic        [DET_W-1:0] det_a4_reg;

    always_comb
    begin
        n_next[0] = (NUM_W'(K125) * NUM_W'(r1_reg)) - (NUM_W'(d12_a3_reg) * NUM_W'(r2_reg));
        n_next[1] = (NUM_W'(d11_a3_reg) * NUM_W'(r2_reg)) - (NUM_W'(d12_a3_reg) * NUM_W'(r1_reg));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_reg[0]   <= n_next[0];
            n_reg[1]   <= n_next[1];
            det_a4_reg <= det_a3_reg;
        end
    end

    // ---------------- divider: setup, then one quotient bit per stage ----------------
    logic [DET_W-1:0] det_reg [DIV_STEPS+1];
    logic [REM_W-1:0] rem_reg [2][DIV_STEPS+1];
    logic [ACC_W-1:0] quo_reg [2][DIV_STEPS+1];
    logic             neg_reg [2][DIV_STEPS+1];
    logic             ovf_reg [2][DIV_STEPS+1];

    always_ff @(posedge clk)
    begin
        if (adv)
            det_reg[0] <= det_a4_reg;
        if (adv)
        begin
            for (int i = 1; i <= DIV_STEPS; i++)
                det_reg[i] <= det_reg[i-1];
        end
    end

    for (genvar ch = 0; ch < 2; ch++)
    begin : g_ch
        logic [NUM_W-1:0] mag;
        logic [NUM_W-1:0] lim;

        // Sign and magnitude; quotients of 2^ACC_W or more saturate at once
        always_comb
        begin
            mag = n_reg[ch][NUM_W-1] ? NUM_W'(-n_reg[ch]) : NUM_W'(n_reg[ch]);
            lim = NUM_W'(det_a4_reg) << ACC_W;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[ch][0] <= mag[REM_W-1:0];
                quo_reg[ch][0] <= '0;
                neg_reg[ch][0] <= n_reg[ch][NUM_W-1];
                ovf_reg[ch][0] <= (mag >= lim);
            end
        end

        for (genvar k = 0; k < DIV_STEPS; k++)
        begin : g_div
            localparam int BIT = DIV_STEPS - 1 - k;
            logic [REM_W-1:0] trial, rem_next;
            logic [ACC_W-1:0] quo_next;

            always_comb
            begin
                trial = REM_W'(det_reg[k]) << BIT;
                if (rem_reg[ch][k] >= trial)
                begin
                    rem_next = rem_reg[ch][k] - trial;
                    quo_next = quo_reg[ch][k] | (ACC_W'(1) << BIT);
                end
                else
                begin
                    rem_next = rem_reg[ch][k];
                    quo_next = quo_reg[ch][k];
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[ch][k+1] <= rem_next;
                    quo_reg[ch][k+1] <= quo_next;
                    neg_reg[ch][k+1] <= neg_reg[ch][k];
                    ovf_reg[ch][k+1] <= ovf_reg[ch][k];
                end
            end
        end
    end

    // ---------------- output: sign and saturation ----------------
    logic signed [ACC_W-1:0] acc_reg [2];
    logic signed [ACC_W-1:0] acc_next [2];

    always_comb
    begin
        for (int ch = 0; ch < 2; ch++)
        begin
            if (ovf_reg[ch][DIV_STEPS])
                acc_next[ch] = neg_reg[ch][DIV_STEPS] ? ACC_MIN : ACC_MAX;
            else if (!neg_reg[ch][DIV_STEPS])
                acc_next[ch] = (quo_reg[ch][DIV_STEPS] > ACC_MAX) ? ACC_MAX
                                                                 : quo_reg[ch][DIV_STEPS];
            else if (quo_reg[ch][DIV_STEPS] > ACC_W'(-ACC_MIN))
                acc_next[ch] = ACC_MIN;
            else
                acc_next[ch] = -quo_reg[ch][DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            acc_reg[0] <= acc_next[0];
            acc_reg[1] <= acc_next[1];
        end
    end

    assign result.shoulder_accel = acc_reg[0];
    assign result.elbow_accel    = acc_reg[1];

    // ---------------- assertions ----------------
    // The determinant fed to the divider is never zero
    a_det_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[V_D0] |-> det_reg[0] != '0)
        else $error("divisor is zero");

    // A stalled output holds every valid bit in the pipe
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipe moved during stall");

    // After the last divider step the shoulder remainder is below the divisor unless saturated
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[V_OUT-1] && !ovf_reg[0][DIV_STEPS])
            |-> rem_reg[0][DIV_STEPS] < REM_W'(det_reg[DIV_STEPS]))
        else $error("shoulder remainder out of range");

    // Stage A1 follows the CORDIC latency exactly
    a_a1_track: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && vld_reg[V_A1 - 1]) |=> vld_reg[V_A1])
        else $error("valid lost entering arithmetic stages");

    // Unused sine outputs of the shoulder-angle units
    logic unused_sin;
    assign unused_sin = ^{sa, sb};

endmodule
